// ===== hw/rtl/coiac_pkg.sv =====
// Shared types and constants for the conflict-of-interest access checker.
package coiac_pkg;

	localparam int NumSubjects = 16;
	localparam int NumObjects  = 256;
	localparam int NumFirms    = 64;
	localparam int NumClasses  = 16;

	localparam int SubjW = $clog2(NumSubjects);
	localparam int ObjW  = $clog2(NumObjects);
	localparam int FirmW = $clog2(NumFirms);
	localparam int ClsW  = $clog2(NumClasses);

	// Field widths of the ports
	localparam int FuncW      = 3;
	localparam int FirmFieldW = 7;
	localparam int ClsFieldW  = 5;
	localparam int StatusW    = 3;

	localparam logic [FirmFieldW-1:0] FirmNone = FirmFieldW'(NumFirms);
	localparam logic [ClsFieldW-1:0]  ClsNone  = ClsFieldW'(NumClasses);

	// Item function codes
	localparam logic [FuncW-1:0] FUNC_SET_OWNER  = 3'd0;
	localparam logic [FuncW-1:0] FUNC_SET_CLASS  = 3'd1;
	localparam logic [FuncW-1:0] FUNC_ADD_SUBJ   = 3'd2;
	localparam logic [FuncW-1:0] FUNC_CLEAR_HIST = 3'd3;
	localparam logic [FuncW-1:0] FUNC_READ       = 3'd4;
	localparam logic [FuncW-1:0] FUNC_WRITE      = 3'd5;

	// Result status codes
	localparam logic [StatusW-1:0] ST_ACCEPTED   = 3'd0;
	localparam logic [StatusW-1:0] ST_REFUSED    = 3'd1;
	localparam logic [StatusW-1:0] ST_NO_SUBJECT = 3'd2;
	localparam logic [StatusW-1:0] ST_NO_OBJECT  = 3'd3;
	localparam logic [StatusW-1:0] ST_SETUP      = 3'd4;

	// Control sequencer, one-hot
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_OWN  = 5'b00010,
		S_CLS  = 5'b00100,
		S_HIT  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	// Query presented to every firm cell
	typedef struct packed {
		logic [ClsFieldW-1:0] chk_class;
		logic                 hist_bit;
		logic                 is_self;
	} cell_query_t;

endpackage

// ===== hw/rtl/coiac_ram.sv =====
// Generic single-port-write RAM with registered read.
module coiac_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/coiac_cell.sv =====
// One firm cell: holds the firm's conflict class and flags a conflict hit.
module coiac_cell
	import coiac_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [ClsFieldW-1:0] wr_class,
	input  cell_query_t          query,
	output logic [ClsFieldW-1:0] cls,
	output logic                 hit
);

	logic [ClsFieldW-1:0] class_q;
	logic                 hit_q;

	// Class storage, reset to "no class"
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_q <= ClsNone;
		end else if (wr_en) begin
			class_q <= wr_class;
		end
	end

	// Touched firm, other than the target, in the same class
	always_ff @(posedge clk) begin
		hit_q <= query.hist_bit && !query.is_self && (class_q == query.chk_class);
	end

	assign cls = class_q;
	assign hit = hit_q;

endmodule

// ===== hw/rtl/conflict_of_interest_access_check_top.sv =====
// Top level of the conflict-of-interest access checker.
// One item is worked on at a time. Setup items (owner load, class load, add
// subject, clear histories, unused codes) go straight to the done state and
// register their result from it. Reads and writes pass in order through one
// owner-table RAM read, one class lookup, one compare across the row of 64 firm
// cells and one reduce and history update. An unknown subject or object ends
// after the owner read and goes straight to the done state. A new item is taken
// in the cycle after its predecessor's result is registered. The result
// register lets the next item start while a result waits for out_ready; an item
// whose result is ready while the register is still full holds until out_ready.
// No clearing pass is needed after reset.
module conflict_of_interest_access_check_top
	import coiac_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [FuncW-1:0]      func,
	input  logic [SubjW-1:0]      subject_id,
	input  logic [ObjW-1:0]       object_id,
	input  logic [FirmFieldW-1:0] firm_id,
	input  logic [ClsFieldW-1:0]  class_id,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [StatusW-1:0]    status
);

	state_t                state_q;
	logic [FuncW-1:0]      func_q;
	logic [SubjW-1:0]      subj_q;
	logic [FirmW-1:0]      firm_q;
	logic [ClsFieldW-1:0]  cls_q;
	logic [NumFirms-1:0]   hist_q;
	logic [StatusW-1:0]    res_q;
	logic                  out_valid_q;
	logic [StatusW-1:0]    status_q;
	logic [NumObjects-1:0] owner_vld_q;
	logic                  own_vld_rd_q;
	logic [NumSubjects-1:0] present_q;
	logic [NumFirms-1:0]   history_q [NumSubjects];

	logic                  in_xfer;
	logic                  own_we;
	logic [FirmFieldW-1:0] own_wdata;
	logic [FirmFieldW-1:0] own_rdata;
	logic [FirmFieldW-1:0] owner;
	logic [ClsFieldW-1:0]  cell_cls [NumFirms];
	logic [NumFirms-1:0]   cell_hit;
	logic                  refuse;
	logic                  out_free;

	assign in_xfer  = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// Owner table write on an owner load
	assign own_we    = in_xfer && (func == FUNC_SET_OWNER);
	assign own_wdata = (firm_id < FirmFieldW'(NumFirms)) ? firm_id : FirmNone;

	coiac_ram #(
		.Width(FirmFieldW),
		.Depth(NumObjects)
	) u_owner_ram (
		.clk   (clk),
		.we    (own_we),
		.waddr (object_id),
		.wdata (own_wdata),
		.raddr (object_id),
		.rdata (own_rdata)
	);

	// Owner entries never written read as unassigned
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_vld_q <= '0;
		end else if (own_we) begin
			owner_vld_q[object_id] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		own_vld_rd_q <= owner_vld_q[object_id];
	end

	assign owner = own_vld_rd_q ? own_rdata : FirmNone;

	// Row of firm cells
	for (genvar g = 0; g < NumFirms; g++) begin : g_cell
		cell_query_t q;
		logic        wr;

		assign q.chk_class = cls_q;
		assign q.hist_bit  = hist_q[g];
		assign q.is_self   = (firm_q == FirmW'(g));
		assign wr = in_xfer && (func == FUNC_SET_CLASS)
			&& (firm_id == FirmFieldW'(g));

		coiac_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (wr),
			.wr_class ((class_id < ClsFieldW'(NumClasses)) ? class_id : ClsNone),
			.query    (q),
			.cls      (cell_cls[g]),
			.hit      (cell_hit[g])
		);
	end

	// Reads ignore classless firms; writes treat them as one class
	assign refuse = (|cell_hit) && ((func_q == FUNC_WRITE) || !cls_q[ClsFieldW-1]);

	// Subject presence and access histories
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			for (int i = 0; i < NumSubjects; i++) begin
				history_q[i] <= '0;
			end
		end else if (in_xfer && (func == FUNC_ADD_SUBJ)) begin
			present_q[subject_id] <= 1'b1;
			history_q[subject_id] <= '0;
		end else if (in_xfer && (func == FUNC_CLEAR_HIST)) begin
			for (int i = 0; i < NumSubjects; i++) begin
				history_q[i] <= '0;
			end
		end else if ((state_q == S_HIT) && !refuse) begin
			history_q[subj_q][firm_q] <= 1'b1;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= ((func == FUNC_READ) || (func == FUNC_WRITE))
							? S_OWN : S_DONE;
					end
				end
				S_OWN: begin
					state_q <= (!present_q[subj_q] || owner[FirmFieldW-1]) ? S_DONE : S_CLS;
				end
				S_CLS:  state_q <= S_HIT;
				S_HIT:  state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item and lookup registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_q <= func;
			subj_q <= subject_id;
			res_q  <= ST_SETUP;
		end
		if (state_q == S_OWN) begin
			firm_q <= owner[FirmW-1:0];
			cls_q  <= cell_cls[owner[FirmW-1:0]];
			hist_q <= history_q[subj_q];
			if (!present_q[subj_q]) begin
				res_q <= ST_NO_SUBJECT;
			end else if (owner[FirmFieldW-1]) begin
				res_q <= ST_NO_OBJECT;
			end
		end
		if (state_q == S_HIT) begin
			res_q <= refuse ? ST_REFUSED : ST_ACCEPTED;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			status_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;

endmodule

// ===== hw/rtl/coiac_checker.sv =====
// Port-level checker for the access checker, bound to the top level.
module coiac_checker
	import coiac_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [FuncW-1:0]   func,
	input logic               out_valid,
	input logic               out_ready,
	input logic [StatusW-1:0] status
);

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("stalled result changed");

	// Status codes stay in range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= ST_SETUP))
		else $error("status out of range");

	// One item at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken while busy");

	// Setup item with a free output reports setup done
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid
		&& (func == FUNC_SET_OWNER || func == FUNC_SET_CLASS
		|| func == FUNC_ADD_SUBJ || func == FUNC_CLEAR_HIST)
		|=> ##1 out_valid && (status == ST_SETUP))
		else $error("setup item result wrong");

endmodule

bind conflict_of_interest_access_check_top coiac_checker u_coiac_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.func      (func),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status)
);
